// ===== sv/u8dec_pkg.sv =====
package u8dec_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POINT_W = 21;
    localparam int unsigned QDEPTH  = 2;

    localparam logic [POINT_W-1:0] SURR_HIGH = 21'h00D800;
    localparam logic [POINT_W-1:0] SURR_LOW  = 21'h00DC00;
    localparam logic [19:0]        SUPP_BASE = 20'h10000;

    localparam logic FMT_UTF32 = 1'b0;
    localparam logic FMT_UTF16 = 1'b1;

    typedef struct packed {
        logic [POINT_W-1:0] code_unit;
        logic               last_of_run;
        logic               end_of_string;
    } result_t;

    // what one decoded byte produces: up to two result items
    typedef struct packed {
        logic [1:0] n_results;
        result_t    r0;
        result_t    r1;
    } dec_out_t;

endpackage

// ===== sv/u8dec_decode.sv =====
module u8dec_decode (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [u8dec_pkg::BYTE_W-1:0] in_byte,
    input  logic                         output_format,
    input  logic                         fire,
    output u8dec_pkg::dec_out_t          dec
);

    logic [1:0]                      bytes_pending_reg, bytes_pending_next;
    logic [u8dec_pkg::POINT_W-1:0]   partial_point_reg, partial_point_next;
    logic                            four_byte_reg, four_byte_next;
    logic [u8dec_pkg::POINT_W-1:0]   point;
    logic [19:0]                     offset;

    always_comb begin
        dec                = '0;
        bytes_pending_next = bytes_pending_reg;
        partial_point_next = partial_point_reg;
        four_byte_next     = four_byte_reg;
        point              = {partial_point_reg[14:0], in_byte[5:0]};
        offset             = point[19:0] - u8dec_pkg::SUPP_BASE;

        if (in_byte == '0) begin
            // terminator: drop any open sequence
            bytes_pending_next = '0;
            partial_point_next = '0;
            four_byte_next     = 1'b0;
            dec.n_results      = 2'd1;
            dec.r0             = '{code_unit: '0, last_of_run: 1'b1, end_of_string: 1'b1};
        end else if (bytes_pending_reg != 2'd0) begin
            // any nonzero byte counts as a continuation here
            bytes_pending_next = bytes_pending_reg - 2'd1;
            if (bytes_pending_reg != 2'd1) begin
                partial_point_next = point;
            end else begin
                partial_point_next = '0;
                four_byte_next     = 1'b0;
                if (four_byte_reg && output_format == u8dec_pkg::FMT_UTF16) begin
                    dec.n_results = 2'd2;
                    dec.r0 = '{code_unit: u8dec_pkg::SURR_HIGH | {11'd0, offset[19:10]},
                               last_of_run: 1'b0, end_of_string: 1'b0};
                    dec.r1 = '{code_unit: u8dec_pkg::SURR_LOW | {11'd0, offset[9:0]},
                               last_of_run: 1'b1, end_of_string: 1'b0};
                end else begin
                    dec.n_results = 2'd1;
                    dec.r0 = '{code_unit: point, last_of_run: 1'b1, end_of_string: 1'b0};
                end
            end
        end else if (!in_byte[7]) begin
            dec.n_results = 2'd1;
            dec.r0 = '{code_unit: {13'd0, in_byte}, last_of_run: 1'b1, end_of_string: 1'b0};
        end else if (in_byte[7:5] == 3'b110) begin
            partial_point_next = {16'd0, in_byte[4:0]};
            bytes_pending_next = 2'd1;
            four_byte_next     = 1'b0;
        end else if (in_byte[7:4] == 4'b1110) begin
            partial_point_next = {17'd0, in_byte[3:0]};
            bytes_pending_next = 2'd2;
            four_byte_next     = 1'b0;
        end else if (in_byte[7:3] == 5'b11110) begin
            partial_point_next = {18'd0, in_byte[2:0]};
            bytes_pending_next = 2'd3;
            four_byte_next     = 1'b1;
        end
        // stray continuation or 11111xxx lead: skip
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_pending_reg <= '0;
            partial_point_reg <= '0;
            four_byte_reg     <= 1'b0;
        end else if (fire) begin
            bytes_pending_reg <= bytes_pending_next;
            partial_point_reg <= partial_point_next;
            four_byte_reg     <= four_byte_next;
        end
    end

endmodule

// ===== sv/u8dec_outq.sv =====
module u8dec_outq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [1:0]          push_n,
    input  u8dec_pkg::result_t  push0,
    input  u8dec_pkg::result_t  push1,
    output logic [1:0]          free_slots,
    output logic                m_valid,
    input  logic                m_ready,
    output u8dec_pkg::result_t  head
);

    u8dec_pkg::result_t q_reg [u8dec_pkg::QDEPTH];
    u8dec_pkg::result_t q_next [u8dec_pkg::QDEPTH];
    logic [1:0]         count_reg, count_next;
    logic [1:0]         count_after;
    logic               pop;

    assign m_valid     = (count_reg != 2'd0);
    assign head        = q_reg[0];
    assign pop         = m_valid && m_ready;
    assign count_after = count_reg - {1'b0, pop};
    assign free_slots  = 2'(u8dec_pkg::QDEPTH) - count_after;

    always_comb begin
        q_next[0] = pop ? q_reg[1] : q_reg[0];
        q_next[1] = q_reg[1];
        if (push_n != 2'd0) begin
            q_next[count_after[0]] = push0;
        end
        if (push_n == 2'd2) begin
            q_next[1] = push1;
        end
        count_next = count_after + push_n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end

endmodule

// ===== sv/utf8_stream_decoder_core.sv =====
// Datapath: an accepted item is held in the input stage, then decoded into the result queue that drives m_*.
// Throughput: one item per cycle while m_ready allows; a surrogate pair fills both queue entries, and the
// bytes of its sequence leave the two-entry result queue room, so input stalls only on m_ready.
// Reset: aresetn low at a clock edge clears the input stage, the result queue, the
// open sequence and output_format (UTF-32).
module utf8_stream_decoder_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [u8dec_pkg::BYTE_W-1:0]  s_in_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [u8dec_pkg::POINT_W-1:0] m_code_unit,
    output logic                          m_last_of_run,
    output logic                          m_end_of_string
);

    logic                         output_format_reg;
    logic                         in_valid_reg, in_valid_next;
    logic [u8dec_pkg::BYTE_W-1:0] in_byte_reg;
    logic                         proceed;
    logic [1:0]                   free_slots;
    u8dec_pkg::dec_out_t          dec;
    u8dec_pkg::result_t           head;

    // advance the held item only when the queue has room for all its results
    assign proceed = in_valid_reg && (dec.n_results <= free_slots);
    assign s_ready = !in_valid_reg || proceed;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (proceed) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            output_format_reg <= u8dec_pkg::FMT_UTF32;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_we) begin
                output_format_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
    end

    u8dec_decode u_decode (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_byte       (in_byte_reg),
        .output_format (output_format_reg),
        .fire          (proceed),
        .dec           (dec)
    );

    u8dec_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_n     (proceed ? dec.n_results : 2'd0),
        .push0      (dec.r0),
        .push1      (dec.r1),
        .free_slots (free_slots),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .head       (head)
    );

    assign m_code_unit     = head.code_unit;
    assign m_last_of_run   = head.last_of_run;
    assign m_end_of_string = head.end_of_string;

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_valid_reg)
        else $error("accepted item not held in input stage");

    a_eos_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_string |-> m_last_of_run)
        else $error("terminator not marked last of run");

    a_pair_only_utf16: assert property (@(posedge aclk) disable iff (!aresetn)
        proceed && dec.n_results == 2'd2 |-> output_format_reg == u8dec_pkg::FMT_UTF16)
        else $error("surrogate pair outside UTF-16 mode");

    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("empty input stage refuses an item");

endmodule

// ===== bench/tb_utf8_stream_decoder_core.sv =====
`timescale 1ns / 1ps

module tb_utf8_stream_decoder_core;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int N_RANDOM_PHASES = 5;
    localparam int PHASE_BYTES = 100;

    typedef struct packed {
        logic [u8dec_pkg::BYTE_W-1:0] value;
        logic                         typed;
        logic [1:0]                   n_typed;
        u8dec_pkg::result_t           typed_unit;
    } stim_item_t;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_COMB
    } sink_mode_t;

    localparam u8dec_pkg::result_t TERMINATOR = '{21'h0, 1'b1, 1'b1};
    localparam u8dec_pkg::result_t NO_UNIT    = '0;

    // UTF-32 rows first; the last two leave a four-byte sequence open across the
    // switch to UTF-16, which the second group completes
    localparam int N_DIRECTED  = 28;
    localparam int PHASE_B_ROW = 18;
    localparam stim_item_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{8'h00, 1'b1, 2'd1, TERMINATOR},
        '{8'h01, 1'b1, 2'd1, '{21'h01, 1'b1, 1'b0}},
        '{8'h7F, 1'b1, 2'd1, '{21'h7F, 1'b1, 1'b0}},
        '{8'h80, 1'b1, 2'd0, NO_UNIT},
        '{8'hFF, 1'b1, 2'd0, NO_UNIT},
        '{8'hC2, 1'b0, 2'd0, NO_UNIT},
        '{8'hA9, 1'b0, 2'd0, NO_UNIT},
        '{8'hF4, 1'b0, 2'd0, NO_UNIT},
        '{8'h8F, 1'b0, 2'd0, NO_UNIT},
        '{8'hBF, 1'b0, 2'd0, NO_UNIT},
        '{8'hBF, 1'b0, 2'd0, NO_UNIT},
        '{8'hE2, 1'b0, 2'd0, NO_UNIT},
        '{8'h41, 1'b0, 2'd0, NO_UNIT},
        '{8'hC3, 1'b0, 2'd0, NO_UNIT},
        '{8'hC3, 1'b0, 2'd0, NO_UNIT},
        '{8'h00, 1'b1, 2'd1, TERMINATOR},
        '{8'hF0, 1'b0, 2'd0, NO_UNIT},
        '{8'h90, 1'b0, 2'd0, NO_UNIT},
        '{8'h80, 1'b0, 2'd0, NO_UNIT},
        '{8'h80, 1'b0, 2'd0, NO_UNIT},
        '{8'hF7, 1'b0, 2'd0, NO_UNIT},
        '{8'hBF, 1'b0, 2'd0, NO_UNIT},
        '{8'hBF, 1'b0, 2'd0, NO_UNIT},
        '{8'hBF, 1'b0, 2'd0, NO_UNIT},
        '{8'hF0, 1'b0, 2'd0, NO_UNIT},
        '{8'h80, 1'b0, 2'd0, NO_UNIT},
        '{8'h80, 1'b0, 2'd0, NO_UNIT},
        '{8'h80, 1'b0, 2'd0, NO_UNIT}
    };

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_we = 1'b0;
    logic                            cfg_wdata = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [u8dec_pkg::BYTE_W-1:0]    s_in_byte = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [u8dec_pkg::POINT_W-1:0]   m_code_unit;
    logic                            m_last_of_run;
    logic                            m_end_of_string;

    stim_item_t                      cur_item = '0;
    stim_item_t                      send_q[$];
    u8dec_pkg::result_t              expected_units[$];
    int unsigned                     errors = 0;
    int unsigned                     idle_cycles = 0;

    // decoder state as the bench sees it
    logic [1:0]                      pend_bytes = '0;
    logic [u8dec_pkg::POINT_W-1:0]   gathered = '0;
    logic                            quad_seq = 1'b0;
    logic                            fmt_now = u8dec_pkg::FMT_UTF32;

    utf8_stream_decoder_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_code_unit     (m_code_unit),
        .m_last_of_run   (m_last_of_run),
        .m_end_of_string (m_end_of_string)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // advance the decoder state by one byte and give the units it emits
    function automatic int unsigned decode_byte(input logic [u8dec_pkg::BYTE_W-1:0] b,
                                                output u8dec_pkg::result_t u0,
                                                output u8dec_pkg::result_t u1);
        logic [u8dec_pkg::POINT_W-1:0] point;
        logic [19:0]                   offs;
        u0 = '0;
        u1 = '0;
        if (b == 8'h00) begin
            pend_bytes = '0;
            gathered = '0;
            quad_seq = 1'b0;
            u0 = TERMINATOR;
            return 1;
        end
        if (pend_bytes != 2'd0) begin
            // any nonzero byte counts as a continuation here
            gathered = {gathered[u8dec_pkg::POINT_W-7:0], b[5:0]};
            pend_bytes = pend_bytes - 2'd1;
            if (pend_bytes != 2'd0)
                return 0;
            point = gathered;
            gathered = '0;
            if (quad_seq && fmt_now == u8dec_pkg::FMT_UTF16) begin
                quad_seq = 1'b0;
                offs = point[19:0] - u8dec_pkg::SUPP_BASE;
                u0.code_unit = u8dec_pkg::SURR_HIGH | {11'b0, offs[19:10]};
                u1.code_unit = u8dec_pkg::SURR_LOW | {11'b0, offs[9:0]};
                u1.last_of_run = 1'b1;
                return 2;
            end
            quad_seq = 1'b0;
            u0.code_unit = point;
            u0.last_of_run = 1'b1;
            return 1;
        end
        if (b[7] == 1'b0) begin
            u0.code_unit = {13'b0, b};
            u0.last_of_run = 1'b1;
            return 1;
        end
        if (b[7:5] == 3'b110) begin
            gathered = {16'b0, b[4:0]};
            pend_bytes = 2'd1;
            quad_seq = 1'b0;
        end else if (b[7:4] == 4'b1110) begin
            gathered = {17'b0, b[3:0]};
            pend_bytes = 2'd2;
            quad_seq = 1'b0;
        end else if (b[7:3] == 5'b11110) begin
            gathered = {18'b0, b[2:0]};
            pend_bytes = 2'd3;
            quad_seq = 1'b1;
        end
        return 0;
    endfunction

    task automatic check_field(input string name, input logic [u8dec_pkg::POINT_W-1:0] want,
                               input logic [u8dec_pkg::POINT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : scoreboard
        u8dec_pkg::result_t got;
        u8dec_pkg::result_t want;
        u8dec_pkg::result_t u0;
        u8dec_pkg::result_t u1;
        int unsigned        n;
        if (!aresetn) begin
            pend_bytes = '0;
            gathered = '0;
            quad_seq = 1'b0;
            fmt_now = u8dec_pkg::FMT_UTF32;
            idle_cycles = 0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_code_unit, m_last_of_run, m_end_of_string};
                if (expected_units.size() == 0) begin
                    $display("%0t: unexpected unit %0h last %0b eos %0b", $time,
                             got.code_unit, got.last_of_run, got.end_of_string);
                    errors++;
                end else begin
                    want = expected_units.pop_front();
                    check_field("code_unit", want.code_unit, got.code_unit);
                    check_field("last_of_run", {20'b0, want.last_of_run},
                                {20'b0, got.last_of_run});
                    check_field("end_of_string", {20'b0, want.end_of_string},
                                {20'b0, got.end_of_string});
                end
            end
            if (s_valid && s_ready) begin
                n = decode_byte(s_in_byte, u0, u1);
                if (cur_item.typed) begin
                    n = cur_item.n_typed;
                    u0 = cur_item.typed_unit;
                end
                if (n > 0)
                    expected_units.push_back(u0);
                if (n > 1)
                    expected_units.push_back(u1);
            end
            if (cfg_we)
                fmt_now = cfg_wdata;
            if ((m_valid && m_ready) || (s_valid && s_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL utf8_stream_decoder_core");
                $finish;
            end
        end
    end

    // receiver: hold each stall mode for a stretch, then pick another
    always @(negedge aclk) begin : sink_pattern
        static sink_mode_t  sink_mode = SINK_OPEN;
        static int unsigned sink_left = 0;
        static logic [7:0]  sink_phase = '0;
        if (sink_left == 0) begin
            sink_mode = sink_mode_t'($urandom_range(3));
            sink_left = $urandom_range(80, 16);
        end
        sink_left--;
        sink_phase++;
        case (sink_mode)
            SINK_OPEN: begin
                m_ready <= 1'b1;
            end
            SINK_COIN: begin
                m_ready <= ($urandom_range(1) == 1);
            end
            SINK_SPARSE: begin
                m_ready <= ($urandom_range(3) == 0);
            end
            default: begin
                m_ready <= sink_phase[2] ^ sink_phase[0];
            end
        endcase
    end

    // called and returns at a falling edge
    task automatic drain_send_q();
        stim_item_t  item;
        int unsigned burst;
        int unsigned gap;
        burst = 0;
        while (send_q.size() != 0) begin
            if (burst == 0) begin
                gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
                burst = $urandom_range(24, 1);
            end
            item = send_q.pop_front();
            s_in_byte <= item.value;
            cur_item <= item;
            s_valid <= 1'b1;
            do @(posedge aclk); while (!s_ready);
            @(negedge aclk);
            burst--;
        end
        s_valid <= 1'b0;
    endtask

    task automatic write_format(input logic f);
        cfg_wdata <= f;
        cfg_we <= 1'b1;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // wait for every expected unit, then let the pipeline empty
    task automatic settle();
        while (expected_units.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic push_byte(input logic [u8dec_pkg::BYTE_W-1:0] b);
        stim_item_t item;
        item = '0;
        item.value = b;
        send_q.push_back(item);
    endtask

    function automatic logic [u8dec_pkg::BYTE_W-1:0] lead_byte(input int unsigned len);
        logic [u8dec_pkg::BYTE_W-1:0] b;
        case (len)
            2: b = 8'hC0 | 8'($urandom_range(31));
            3: b = 8'hE0 | 8'($urandom_range(15));
            default: b = 8'hF0 | 8'($urandom_range(7));
        endcase
        return b;
    endfunction

    function automatic logic [u8dec_pkg::BYTE_W-1:0] cont_byte();
        logic [u8dec_pkg::BYTE_W-1:0] b;
        // mostly proper continuations, now and then any nonzero byte
        if ($urandom_range(15) == 0)
            b = 8'($urandom_range(255, 1));
        else
            b = 8'h80 | 8'($urandom_range(63));
        return b;
    endfunction

    task automatic queue_random_text(input int unsigned n_target);
        int unsigned counted;
        int unsigned kind;
        int unsigned len;
        int unsigned n_cont;
        counted = 0;
        while (counted < n_target) begin
            kind = $urandom_range(99);
            if (kind < 30) begin
                push_byte(8'($urandom_range(127, 1)));
                counted++;
            end else if (kind < 85) begin
                len = (kind < 50) ? 2 : (kind < 68) ? 3 : 4;
                push_byte(lead_byte(len));
                repeat (len - 1) push_byte(cont_byte());
                counted += len;
            end else if (kind < 89) begin
                push_byte(8'h00);
                counted++;
            end else if (kind < 93) begin
                push_byte(8'($urandom_range(8'hBF, 8'h80)));
            end else if (kind < 95) begin
                push_byte(8'($urandom_range(8'hFF, 8'hF8)));
            end else if (kind < 98) begin
                // cut a sequence short; what follows is taken as its continuation
                len = $urandom_range(4, 2);
                n_cont = $urandom_range(len - 2);
                push_byte(lead_byte(len));
                repeat (n_cont) push_byte(cont_byte());
                counted += n_cont + 1;
                if ($urandom_range(1) == 1) begin
                    push_byte(8'h00);
                    counted++;
                end
            end else begin
                push_byte(8'($urandom_range(255)));
                counted++;
            end
        end
    endtask

    initial begin : stimulus
        int p;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_format(u8dec_pkg::FMT_UTF32);
        for (int i = 0; i < PHASE_B_ROW; i++)
            send_q.push_back(DIRECTED_ROWS[i]);
        drain_send_q();
        settle();

        // the open four-byte sequence completes under the new format
        write_format(u8dec_pkg::FMT_UTF16);
        for (int i = PHASE_B_ROW; i < N_DIRECTED; i++)
            send_q.push_back(DIRECTED_ROWS[i]);
        drain_send_q();
        settle();

        for (p = 0; p < N_RANDOM_PHASES; p++) begin
            if (p == 0)
                write_format(u8dec_pkg::FMT_UTF32);
            else if (p == 1)
                write_format(u8dec_pkg::FMT_UTF16);
            else
                write_format(1'($urandom_range(1)));
            queue_random_text(PHASE_BYTES);
            drain_send_q();
            settle();
        end

        if (errors == 0) begin
            $display("PASS utf8_stream_decoder_core");
        end else begin
            $display("FAIL utf8_stream_decoder_core");
        end
        $finish;
    end

endmodule
